// ----- rtl/core/tvg_pkg.sv -----
// ----------------------------------------------------------------------------
// tvg_pkg
// Shared constants and types for the triangle tessellation vertex unit.
// ----------------------------------------------------------------------------
package tvg_pkg;

   // default coordinate width (signed Q8.8)
   localparam int TVG_COORD_BITS = 16;

   // upper bound on the effective segment count
   localparam logic [15:0] TVG_MAX_SEGMENTS = 16'd255;

   // Q1.16 fractions
   localparam int FRAC_W = 17;
   localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'h10000;
   localparam logic [FRAC_W-1:0] FRAC_HALF = 17'h08000;

   // quotient bits produced by the divider
   localparam int DIV_STEPS = 16;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // csr port
   localparam int CSR_DATA_W = 48;
   localparam int CSR_IDX_W  = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_A = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_B = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_APEX     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENTS = 3'd4;

   // divider request and response
   typedef struct packed {
      logic       start;
      logic [7:0] num;
      logic [7:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_STEPS-1:0] quo;
   } div_rsp_type;

endpackage

// ----- rtl/core/triangle_tessellation_vertex_gen_unit.sv -----
// ----------------------------------------------------------------------------
// triangle_tessellation_vertex_gen_unit
// Walks a uniform triangle grid row by row, one vertex per request transfer.
// ----------------------------------------------------------------------------
// Sequence: a grid vertex takes two divisions and nine interpolations; when
//   the column ends its row, u saturates without a division; the apex vertex
//   or an error goes straight to the output register.
// Flow: one request at a time; the next is taken once the result is in the
//   output register, which waits while a held result is not taken.
// Reset: synchronous, clears the walk and the configuration registers, segment count one.
module triangle_tessellation_vertex_gen_unit
   import tvg_pkg::*;
#(
   parameter int COORD_BITS = TVG_COORD_BITS
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_restart,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_pos_x,
   output logic signed [COORD_BITS-1:0] rsp_pos_y,
   output logic signed [COORD_BITS-1:0] rsp_pos_z,
   output logic [FRAC_W-1:0]            rsp_tex_u,
   output logic [FRAC_W-1:0]            rsp_tex_v,
   output logic [CSR_DATA_W-1:0]        rsp_normal_out,
   output logic                         rsp_last_vertex,
   output logic                         rsp_error,
   input  logic                         csr_wr_en,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   localparam int PACK_W = (3 * COORD_BITS > CSR_DATA_W) ? 3 * COORD_BITS : CSR_DATA_W;
   localparam logic [COORD_BITS-1:0] BIAS = {1'b1, {(COORD_BITS - 1){1'b0}}};

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_T_GO   = 3'd1;
   localparam logic [2:0] ST_T_WAIT = 3'd2;
   localparam logic [2:0] ST_U_GO   = 3'd3;
   localparam logic [2:0] ST_U_WAIT = 3'd4;
   localparam logic [2:0] ST_L_GO   = 3'd5;
   localparam logic [2:0] ST_L_WAIT = 3'd6;
   localparam logic [2:0] ST_OUT    = 3'd7;

   // result kinds
   localparam logic [1:0] KIND_GRID = 2'd0;
   localparam logic [1:0] KIND_APEX = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // interpolation steps per coordinate
   localparam logic [1:0] STEP_E1  = 2'd0;
   localparam logic [1:0] STEP_E2  = 2'd1;
   localparam logic [1:0] STEP_MIX = 2'd2;

   // coordinate selects
   localparam logic [1:0] CRD_X = 2'd0;
   localparam logic [1:0] CRD_Y = 2'd1;
   localparam logic [1:0] CRD_Z = 2'd2;

   // configuration registers
   logic [CSR_DATA_W-1:0] corner_a_ff, corner_b_ff, apex_ff, normal_ff;
   logic [7:0]            seg_ff;

   // sequencer and walk state
   logic [2:0]            state_ff, state_in;
   logic [8:0]            row_cnt_ff, row_cnt_in;
   logic [7:0]            col_cnt_ff, col_cnt_in;
   logic [1:0]            kind_ff, kind_in;
   logic [7:0]            row_w_ff, row_w_in;
   logic [7:0]            col_w_ff, col_w_in;
   logic [7:0]            left_ff, left_in;
   logic [7:0]            s_ff, s_in;
   logic [DIV_STEPS-1:0]  t_ff, t_in;
   logic [FRAC_W-1:0]     u_ff, u_in;
   logic [1:0]            crd_ff, crd_in;
   logic [1:0]            step_ff, step_in;
   logic [COORD_BITS-1:0] e1_ff, e1_in;
   logic [COORD_BITS-1:0] e2_ff, e2_in;
   logic [COORD_BITS-1:0] pos_ff [3];
   logic [COORD_BITS-1:0] pos_in [3];

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] rsp_pos_ff [3];
   logic [COORD_BITS-1:0] rsp_pos_in [3];
   logic [FRAC_W-1:0]     rsp_tex_u_ff, rsp_tex_u_in;
   logic [FRAC_W-1:0]     rsp_tex_v_ff, rsp_tex_v_in;
   logic [CSR_DATA_W-1:0] rsp_normal_ff, rsp_normal_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_error_ff, rsp_error_in;
   logic                  rsp_load;

   // coordinate slices
   logic [PACK_W-1:0]     a_ext, b_ext, c_ext;
   logic [COORD_BITS-1:0] a_crd [3];
   logic [COORD_BITS-1:0] b_crd [3];
   logic [COORD_BITS-1:0] c_crd [3];

   // request decode
   logic                  accept;
   logic [7:0]            seg_eff;
   logic [8:0]            s9;
   logic [8:0]            row_eff;
   logic [7:0]            col_eff;
   logic [8:0]            left9;
   logic                  is_err, is_apex, wrap;

   // shared units
   div_req_type           div_req;
   div_rsp_type           div_rsp;
   logic                  lerp_start;
   logic [COORD_BITS-1:0] lerp_p, lerp_q, lerp_res;
   logic [FRAC_W-1:0]     lerp_f;
   logic                  lerp_done;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         corner_a_ff <= '0;
         corner_b_ff <= '0;
         apex_ff     <= '0;
         normal_ff   <= '0;
         seg_ff      <= 8'd1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CORNER_A: corner_a_ff <= csr_wdata;
            CSR_CORNER_B: corner_b_ff <= csr_wdata;
            CSR_APEX:     apex_ff     <= csr_wdata;
            CSR_NORMAL:   normal_ff   <= csr_wdata;
            CSR_SEGMENTS: seg_ff      <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // unpack x y z, zero padded above the register
   always_comb begin
      a_ext = PACK_W'(corner_a_ff);
      b_ext = PACK_W'(corner_b_ff);
      c_ext = PACK_W'(apex_ff);
      for (int i = 0; i < 3; i++) begin
         a_crd[i] = a_ext[i*COORD_BITS +: COORD_BITS];
         b_crd[i] = b_ext[i*COORD_BITS +: COORD_BITS];
         c_crd[i] = c_ext[i*COORD_BITS +: COORD_BITS];
      end
   end

   // effective segment count and position checks
   always_comb begin
      if (seg_ff == 8'd0) begin
         seg_eff = 8'd1;
      end else if ({8'd0, seg_ff} > TVG_MAX_SEGMENTS) begin
         seg_eff = TVG_MAX_SEGMENTS[7:0];
      end else begin
         seg_eff = seg_ff;
      end
      s9      = {1'b0, seg_eff};
      row_eff = req_restart ? 9'd0 : row_cnt_ff;
      col_eff = req_restart ? 8'd0 : col_cnt_ff;
      is_err  = (row_eff > s9);
      is_apex = (row_eff == s9);
      left9   = s9 - row_eff;
      wrap    = (({1'b0, col_eff} + 9'd1) > left9);
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   // interpolation operand select
   always_comb begin
      lerp_p = e1_ff;
      lerp_q = e2_ff;
      lerp_f = u_ff;
      case (step_ff)
         STEP_E1: begin
            lerp_p = a_crd[crd_ff] ^ BIAS;
            lerp_q = c_crd[crd_ff] ^ BIAS;
            lerp_f = {1'b0, t_ff};
         end
         STEP_E2: begin
            lerp_p = b_crd[crd_ff] ^ BIAS;
            lerp_q = c_crd[crd_ff] ^ BIAS;
            lerp_f = {1'b0, t_ff};
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      row_cnt_in = row_cnt_ff;
      col_cnt_in = col_cnt_ff;
      kind_in    = kind_ff;
      row_w_in   = row_w_ff;
      col_w_in   = col_w_ff;
      left_in    = left_ff;
      s_in       = s_ff;
      t_in       = t_ff;
      u_in       = u_ff;
      crd_in     = crd_ff;
      step_in    = step_ff;
      e1_in      = e1_ff;
      e2_in      = e2_ff;
      pos_in     = pos_ff;
      div_req    = '0;
      lerp_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               s_in     = seg_eff;
               row_w_in = row_eff[7:0];
               col_w_in = col_eff;
               left_in  = left9[7:0];
               crd_in   = CRD_X;
               step_in  = STEP_E1;
               if (is_err) begin
                  kind_in  = KIND_ERR;
                  state_in = ST_OUT;
               end else begin
                  // advance column, or move to the next row
                  if (wrap) begin
                     col_cnt_in = 8'd0;
                     row_cnt_in = row_eff + 9'd1;
                  end else begin
                     col_cnt_in = col_eff + 8'd1;
                     row_cnt_in = row_eff;
                  end
                  if (is_apex) begin
                     kind_in  = KIND_APEX;
                     state_in = ST_OUT;
                  end else begin
                     kind_in  = KIND_GRID;
                     state_in = ST_T_GO;
                  end
               end
            end
         end
         ST_T_GO: begin
            div_req.start = 1'b1;
            div_req.num   = row_w_ff;
            div_req.den   = s_ff;
            state_in      = ST_T_WAIT;
         end
         ST_T_WAIT: begin
            if (div_rsp.done) begin
               t_in     = div_rsp.quo;
               state_in = ST_U_GO;
            end
         end
         ST_U_GO: begin
            // column at or past its row end saturates to one
            if (col_w_ff >= left_ff) begin
               u_in     = FRAC_ONE;
               state_in = ST_L_GO;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = col_w_ff;
               div_req.den   = left_ff;
               state_in      = ST_U_WAIT;
            end
         end
         ST_U_WAIT: begin
            if (div_rsp.done) begin
               u_in     = {1'b0, div_rsp.quo};
               state_in = ST_L_GO;
            end
         end
         ST_L_GO: begin
            lerp_start = 1'b1;
            state_in   = ST_L_WAIT;
         end
         ST_L_WAIT: begin
            if (lerp_done) begin
               state_in = ST_L_GO;
               case (step_ff)
                  STEP_E1: begin
                     e1_in   = lerp_res;
                     step_in = STEP_E2;
                  end
                  STEP_E2: begin
                     e2_in   = lerp_res;
                     step_in = STEP_MIX;
                  end
                  default: begin
                     pos_in[crd_ff] = lerp_res ^ BIAS;
                     step_in        = STEP_E1;
                     if (crd_ff == CRD_Z) begin
                        state_in = ST_OUT;
                     end else begin
                        crd_in = crd_ff + 2'd1;
                     end
                  end
               endcase
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register load
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_pos_in    = rsp_pos_ff;
      rsp_tex_u_in  = rsp_tex_u_ff;
      rsp_tex_v_in  = rsp_tex_v_ff;
      rsp_normal_in = rsp_normal_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_error_in  = rsp_error_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         case (kind_ff)
            KIND_APEX: begin
               rsp_pos_in    = c_crd;
               rsp_tex_u_in  = FRAC_HALF;
               rsp_tex_v_in  = FRAC_ONE;
               rsp_normal_in = normal_ff;
               rsp_last_in   = 1'b1;
               rsp_error_in  = 1'b0;
            end
            KIND_GRID: begin
               rsp_pos_in    = pos_ff;
               rsp_tex_u_in  = u_ff;
               rsp_tex_v_in  = {1'b0, t_ff};
               rsp_normal_in = normal_ff;
               rsp_last_in   = 1'b0;
               rsp_error_in  = 1'b0;
            end
            default: begin
               for (int i = 0; i < 3; i++) begin
                  rsp_pos_in[i] = '0;
               end
               rsp_tex_u_in  = '0;
               rsp_tex_v_in  = '0;
               rsp_normal_in = '0;
               rsp_last_in   = 1'b0;
               rsp_error_in  = 1'b1;
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_cnt_ff   <= '0;
         col_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         crd_ff       <= CRD_X;
         step_ff      <= STEP_E1;
         kind_ff      <= KIND_GRID;
      end else begin
         state_ff     <= state_in;
         row_cnt_ff   <= row_cnt_in;
         col_cnt_ff   <= col_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         crd_ff       <= crd_in;
         step_ff      <= step_in;
         kind_ff      <= kind_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      row_w_ff      <= row_w_in;
      col_w_ff      <= col_w_in;
      left_ff       <= left_in;
      s_ff          <= s_in;
      t_ff          <= t_in;
      u_ff          <= u_in;
      e1_ff         <= e1_in;
      e2_ff         <= e2_in;
      pos_ff        <= pos_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_tex_u_ff  <= rsp_tex_u_in;
      rsp_tex_v_ff  <= rsp_tex_v_in;
      rsp_normal_ff <= rsp_normal_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_error_ff  <= rsp_error_in;
   end

   // shared divider
   tvg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // shared interpolation unit
   tvg_lerp #(
      .COORD_BITS (COORD_BITS)
   ) u_lerp (
      .clock (clock),
      .reset (reset),
      .start (lerp_start),
      .p     (lerp_p),
      .q     (lerp_q),
      .f     (lerp_f),
      .done  (lerp_done),
      .res   (lerp_res)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = rsp_pos_ff[0];
   assign rsp_pos_y       = rsp_pos_ff[1];
   assign rsp_pos_z       = rsp_pos_ff[2];
   assign rsp_tex_u       = rsp_tex_u_ff;
   assign rsp_tex_v       = rsp_tex_v_ff;
   assign rsp_normal_out  = rsp_normal_ff;
   assign rsp_last_vertex = rsp_last_ff;
   assign rsp_error       = rsp_error_ff;

endmodule

// ----- rtl/core/tvg_div.sv -----
// ----------------------------------------------------------------------------
// tvg_div
// Restoring divider, one quotient bit per cycle: floor(num * 2^16 / den)
// for num < den, giving a 16-bit fraction.
// ----------------------------------------------------------------------------
module tvg_div
   import tvg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [7:0]           rem_ff, rem_in;
   logic [7:0]           den_ff, den_in;
   logic [DIV_STEPS-1:0] quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [8:0]           rem_dbl;
   logic [8:0]           rem_sub;
   logic                 fits;

   // one shift and trial subtract per cycle
   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_dbl = {rem_ff, 1'b0};
      rem_sub = rem_dbl - {1'b0, den_ff};
      fits    = (rem_dbl >= {1'b0, den_ff});
      if (div_req.start) begin
         rem_in  = div_req.num;
         den_in  = div_req.den;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sub[7:0] : rem_dbl[7:0];
         quo_in = {quo_ff[DIV_STEPS-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule

// ----- rtl/core/tvg_lerp.sv -----
// ----------------------------------------------------------------------------
// tvg_lerp
// Shared interpolation unit: p + floor((q - p) * f / 2^16) on biased
// unsigned coordinates, f in Q1.16. Multiply in one cycle, add in the next.
// ----------------------------------------------------------------------------
module tvg_lerp
   import tvg_pkg::*;
#(
   parameter int COORD_BITS = TVG_COORD_BITS
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COORD_BITS-1:0] p,
   input  logic [COORD_BITS-1:0] q,
   input  logic [FRAC_W-1:0]     f,
   output logic                  done,
   output logic [COORD_BITS-1:0] res
);

   localparam int DIFF_W = COORD_BITS + 1;
   localparam int PROD_W = DIFF_W + FRAC_W + 1;
   localparam int SUM_W  = PROD_W - 16;

   logic signed [DIFF_W-1:0]  diff;
   logic signed [FRAC_W:0]    f_s;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [COORD_BITS-1:0]     p_ff;
   logic signed [SUM_W-1:0]   p_ext;
   logic signed [SUM_W-1:0]   sum;
   logic [COORD_BITS-1:0]     res_ff;
   logic                      stage_ff;
   logic                      done_ff;

   // stage one: signed difference times fraction
   always_comb begin
      diff    = $signed({1'b0, q}) - $signed({1'b0, p});
      f_s     = $signed({1'b0, f});
      prod_in = diff * f_s;
   end

   // stage two: floor shift and add base
   always_comb begin
      p_ext = $signed({{(SUM_W - COORD_BITS){1'b0}}, p_ff});
      sum   = $signed(prod_ff[PROD_W-1:16]) + p_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= start;
         done_ff  <= stage_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= prod_in;
         p_ff    <= p;
      end
      if (stage_ff) begin
         res_ff <= sum[COORD_BITS-1:0];
      end
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

// ----- rtl/core/tvg_checker.sv -----
// ----------------------------------------------------------------------------
// tvg_checker
// Port-level checks for the triangle tessellation vertex unit.
// ----------------------------------------------------------------------------
module tvg_checker
   import tvg_pkg::*;
#(
   parameter int COORD_BITS = TVG_COORD_BITS
)
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [COORD_BITS-1:0] rsp_pos_x,
   input logic signed [COORD_BITS-1:0] rsp_pos_y,
   input logic signed [COORD_BITS-1:0] rsp_pos_z,
   input logic [FRAC_W-1:0]            rsp_tex_u,
   input logic [FRAC_W-1:0]            rsp_tex_v,
   input logic [CSR_DATA_W-1:0]        rsp_normal_out,
   input logic                         rsp_last_vertex,
   input logic                         rsp_error
);

   // a pending result is not dropped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   // one request in flight: ready drops after a request transfer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // error results carry nothing else
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> !rsp_last_vertex && rsp_pos_x == '0 &&
         rsp_pos_y == '0 && rsp_pos_z == '0 && rsp_tex_u == '0 &&
         rsp_tex_v == '0 && rsp_normal_out == '0)
      else $error("error result with nonzero fields");

   // apex carries fixed texture coordinates
   a_apex_tex: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_vertex |-> rsp_tex_u == FRAC_HALF && rsp_tex_v == FRAC_ONE)
      else $error("apex texture coordinates wrong");

   // fractions stay within one
   a_tex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tex_u <= FRAC_ONE && rsp_tex_v <= FRAC_ONE)
      else $error("texture fraction above one");

endmodule

bind triangle_tessellation_vertex_gen_unit tvg_checker #(
   .COORD_BITS (COORD_BITS)
) u_tvg_checker (.*);
